[sv/gtsg_pkg.sv]
// Package for the gripper trapezoid setpoint generator.
// Holds the item types, the profile constants and the divider result type.
// No dependencies; every other file imports it.
package gtsg_pkg;

	localparam int MAX_KNOTS  = 4;
	localparam int KNOT_STORE = 4;
	localparam int QUOT_W     = 29;

	localparam logic [31:0]        RAMP_TIME_US = 32'd84000;
	localparam logic signed [27:0] RAMP_DIST    = 28'sd176400;
	localparam logic signed [19:0] PEAK_SPEED   = 20'sd420000;
	localparam logic [28:0]        TRI_LIMIT    = 29'd352800;
	localparam logic [31:0]        TIME_SCALE   = 32'd5;
	localparam logic [31:0]        SPEED_SCALE  = 32'd25;
	localparam logic [31:0]        SCALE_DIV    = 32'd21;
	localparam logic [19:0]        EPS_RESET    = 20'd10;

	typedef struct packed {
		logic               operation;
		logic [31:0]        time_us;
		logic [17:0]        command_width_um;
		logic               command_valid;
		logic signed [27:0] current_position;
	} cmd_item_t;

	typedef struct packed {
		logic signed [27:0] setpoint_position;
		logic signed [19:0] setpoint_velocity;
		logic               profile_active;
	} sp_item_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_res_t;

endpackage

[sv/gtsg_div.sv]
// Shared multiply-divide unit: quot = floor(a * b / d), one quotient bit a cycle.
// Requires a * b < d * 2^29. Depends on gtsg_pkg.
module gtsg_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [28:0]      a,
	input  logic [31:0]      b,
	input  logic [31:0]      d,
	output gtsg_pkg::div_res_t res
);
	import gtsg_pkg::*;

	logic              ld_q;
	logic              run_q;
	logic [4:0]        cnt_q;
	logic              done_q;
	logic [60:0]       prod_q;
	logic [31:0]       d_q;
	logic [31:0]       rem_q;
	logic [28:0]       low_q;
	logic [QUOT_W-1:0] quot_q;
	logic [32:0]       rem2;
	logic              ge;

	assign rem2 = {rem_q, low_q[28]};
	assign ge   = (rem2 >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q   <= 1'b0;
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			ld_q   <= start;
			done_q <= run_q && (cnt_q == 5'd1);
			if (ld_q) begin
				run_q <= 1'b1;
				cnt_q <= 5'(QUOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= {32'b0, a} * {29'b0, b};
			d_q    <= d;
		end
		if (ld_q) begin
			rem_q  <= prod_q[60:29];
			low_q  <= prod_q[28:0];
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= ge ? 32'(rem2 - {1'b0, d_q}) : rem2[31:0];
			low_q  <= {low_q[27:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

[sv/gripper_trapezoid_setpoint_generator_core.sv]
// Top level of the gripper trapezoid setpoint generator.
// Instantiates gtsg_div; depends on gtsg_pkg.
//
// Each command item carries a time stamp, the measured actuator position and, for an update,
// a commanded finger width; the block answers every item with exactly one setpoint item.
// An update maps the width to an actuator target of minus five times the width and, when the
// target moves by more than target_epsilon, plans a triangular or trapezoidal profile from the
// measured position (at most 420000 um/s and 5000000 um/s^2) and stores three or four knots.
// The setpoint is then interpolated between knots at the time elapsed since the plan, held at
// the last knot after the end, and equals the measured position with zero velocity while no
// profile exists. The block works on one item at a time: cmd_stall is high from acceptance
// until the result has been placed in the output register, and a result waiting there does not
// hold off the next item. All scaling and interpolation run through one shared multiply and
// divide unit that yields one quotient bit a cycle. An item that evaluates a stored profile
// inside its span takes two passes of that unit; an item that plans a profile adds one pass
// for a trapezoid and two passes for a triangle; an item with no profile or past the end
// uses no pass of the unit.
// target_epsilon is written through the cfg channel, which is always ready and must be used
// only while the block is idle.
module gripper_trapezoid_setpoint_generator_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  gtsg_pkg::cmd_item_t   cmd_item,
	output logic                  sp_valid,
	input  logic                  sp_stall,
	output gtsg_pkg::sp_item_t    sp_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [19:0]           cfg_data
);
	import gtsg_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_CMP  = 13'b0000000000010,
		S_PLAN = 13'b0000000000100,
		S_D1   = 13'b0000000001000,
		S_D2   = 13'b0000000010000,
		S_WR   = 13'b0000000100000,
		S_EVAL = 13'b0000001000000,
		S_SRCH = 13'b0000010000000,
		S_LD0  = 13'b0000100000000,
		S_PSET = 13'b0001000000000,
		S_PDIV = 13'b0010000000000,
		S_VDIV = 13'b0100000000000,
		S_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Control state.
	logic               have_q;
	logic [2:0]         kcnt_q;
	logic signed [27:0] last_target_q;
	logic [31:0]        start_q;
	logic [19:0]        eps_q;
	logic               sp_valid_q;
	logic               div_go_q;

	// Item and working registers.
	logic               op_q;
	logic [31:0]        time_q;
	logic signed [27:0] pos_q;
	logic signed [27:0] target_q;
	logic [28:0]        delta_q;
	logic               dir_q;
	logic               tri_q;
	logic [31:0]        rel_q;
	logic [28:0]        mt_q;
	logic [28:0]        tc_q;
	logic signed [19:0] peak_q;
	logic [1:0]         idx_q;
	logic [31:0]        t0_q;
	logic [31:0]        t1_q;
	logic signed [27:0] p0_q;
	logic signed [27:0] p1_q;
	logic signed [19:0] v0_q;
	logic signed [19:0] v1_q;
	logic [31:0]        e_q;
	logic [31:0]        dt_q;
	logic               pneg_q;
	logic               vneg_q;
	logic [20:0]        vmag_q;
	logic signed [27:0] res_pos_q;
	logic signed [19:0] res_vel_q;
	logic               res_act_q;
	sp_item_t           sp_q;
	logic [28:0]        div_a_q;
	logic [31:0]        div_b_q;
	logic [31:0]        div_d_q;

	// Knot store.
	logic signed [27:0] kpos_q  [KNOT_STORE];
	logic signed [19:0] kvel_q  [KNOT_STORE];
	logic [31:0]        ktime_q [KNOT_STORE];

	div_res_t div_res;

	logic [20:0]        w5;
	logic signed [28:0] tdiff;
	logic [28:0]        tdiff_mag;
	logic               plan;
	logic signed [28:0] pdiff;
	logic               tri_c;
	logic [1:0]         last_idx;
	logic [1:0]         rd_idx;
	logic signed [27:0] rd_pos;
	logic signed [19:0] rd_vel;
	logic [31:0]        rd_time;
	logic signed [28:0] dp;
	logic signed [20:0] dv;
	logic [27:0]        half;
	logic signed [19:0] vpeak;
	logic signed [27:0] ramp_off;
	logic signed [19:0] cruise_v;

	gtsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.a      (div_a_q),
		.b      (div_b_q),
		.d      (div_d_q),
		.res    (div_res)
	);

	assign w5 = {1'b0, cmd_item.command_width_um, 2'b0} + {3'b0, cmd_item.command_width_um};

	// Epsilon test against the last target, and the move length from the measured position.
	assign tdiff     = {target_q[27], target_q} - {last_target_q[27], last_target_q};
	assign tdiff_mag = tdiff[28] ? 29'(-tdiff) : 29'(tdiff);
	assign plan      = op_q && (tdiff_mag > {9'b0, eps_q});
	assign pdiff     = {target_q[27], target_q} - {pos_q[27], pos_q};
	assign tri_c     = (delta_q < TRI_LIMIT);

	// One knot read port; its address follows the sequencer.
	assign last_idx = 2'(kcnt_q - 3'd1);
	always_comb begin
		case (state_q)
			S_EVAL:  rd_idx = last_idx;
			S_SRCH:  rd_idx = 2'(idx_q + 2'd1);
			default: rd_idx = idx_q;
		endcase
	end
	assign rd_pos  = kpos_q[rd_idx];
	assign rd_vel  = kvel_q[rd_idx];
	assign rd_time = ktime_q[rd_idx];

	assign dp       = {p1_q[27], p1_q} - {p0_q[27], p0_q};
	assign dv       = {v1_q[19], v1_q} - {v0_q[19], v0_q};
	assign half     = delta_q[28:1];
	assign vpeak    = dir_q ? peak_q : -peak_q;
	assign ramp_off = dir_q ? RAMP_DIST : -RAMP_DIST;
	assign cruise_v = dir_q ? PEAK_SPEED : -PEAK_SPEED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			have_q        <= 1'b0;
			kcnt_q        <= '0;
			last_target_q <= '0;
			start_q       <= '0;
			eps_q         <= EPS_RESET;
			sp_valid_q    <= 1'b0;
			div_go_q      <= 1'b0;
		end else begin
			// The divider starts one pass per request, for the plan and for each interpolation.
			div_go_q <= (state_q == S_PLAN) || (state_q == S_PSET) ||
			            (state_q == S_D1 && div_res.done && tri_q && div_res.quot != '0) ||
			            (state_q == S_PDIV && div_res.done);
			if (cfg_valid) begin
				eps_q <= cfg_data;
			end
			if (state_q == S_OUT && (!sp_valid_q || !sp_stall)) begin
				sp_valid_q <= 1'b1;
			end else if (sp_valid_q && !sp_stall) begin
				sp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (plan) begin
						last_target_q <= target_q;
						start_q       <= time_q;
						state_q       <= S_PLAN;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_PLAN: begin
					state_q <= S_D1;
				end
				S_D1: begin
					if (div_res.done) begin
						if (!tri_q) begin
							state_q <= S_WR;
						end else if (div_res.quot == '0) begin
							// Move too short for a nonzero ramp time: drop any stored profile.
							have_q  <= 1'b0;
							kcnt_q  <= '0;
							state_q <= S_EVAL;
						end else begin
							state_q <= S_D2;
						end
					end
				end
				S_D2: begin
					if (div_res.done) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					have_q  <= 1'b1;
					kcnt_q  <= (tri_q || MAX_KNOTS < 4) ? 3'd3 : 3'd4;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!have_q || rel_q >= rd_time) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (rel_q < rd_time) begin
						state_q <= S_LD0;
					end
				end
				S_LD0: begin
					state_q <= S_PSET;
				end
				S_PSET: begin
					state_q <= S_PDIV;
				end
				S_PDIV: begin
					if (div_res.done) begin
						state_q <= S_VDIV;
					end
				end
				S_VDIV: begin
					if (div_res.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!sp_valid_q || !sp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op_q     <= cmd_item.operation;
					time_q   <= cmd_item.time_us;
					pos_q    <= cmd_item.current_position;
					target_q <= cmd_item.command_valid ? -$signed({7'b0, w5}) : '0;
				end
			end
			S_CMP: begin
				delta_q <= pdiff[28] ? 29'(-pdiff) : 29'(pdiff);
				dir_q   <= !pdiff[28] && (pdiff != '0);
				// A new plan starts its clock at this item's time stamp.
				rel_q   <= plan ? '0 : time_q - start_q;
			end
			S_PLAN: begin
				tri_q   <= tri_c;
				div_a_q <= tri_c ? delta_q : delta_q - TRI_LIMIT;
				div_b_q <= TIME_SCALE;
				div_d_q <= SCALE_DIV;
			end
			S_D1: begin
				if (div_res.done) begin
					mt_q    <= div_res.quot;
					tc_q    <= div_res.quot;
					div_a_q <= delta_q;
					div_b_q <= SPEED_SCALE;
				end
			end
			S_D2: begin
				if (div_res.done) begin
					peak_q <= 20'(div_res.quot);
				end
			end
			S_WR: begin
				kpos_q[0]  <= pos_q;
				kvel_q[0]  <= '0;
				ktime_q[0] <= '0;
				if (tri_q) begin
					kpos_q[1]  <= dir_q ? pos_q + $signed(half) : pos_q - $signed(half);
					kvel_q[1]  <= vpeak;
					ktime_q[1] <= 32'(mt_q);
					kpos_q[2]  <= target_q;
					kvel_q[2]  <= '0;
					ktime_q[2] <= 32'({mt_q, 1'b0});
				end else begin
					kpos_q[1]  <= pos_q + ramp_off;
					kvel_q[1]  <= cruise_v;
					ktime_q[1] <= RAMP_TIME_US;
					if (MAX_KNOTS < 4) begin
						kpos_q[2]  <= target_q;
						kvel_q[2]  <= '0;
						ktime_q[2] <= 32'(tc_q) + {RAMP_TIME_US[30:0], 1'b0};
					end else begin
						kpos_q[2]  <= target_q - ramp_off;
						kvel_q[2]  <= cruise_v;
						ktime_q[2] <= 32'(tc_q) + RAMP_TIME_US;
						kpos_q[3]  <= target_q;
						kvel_q[3]  <= '0;
						ktime_q[3] <= 32'(tc_q) + {RAMP_TIME_US[30:0], 1'b0};
					end
				end
			end
			S_EVAL: begin
				idx_q <= '0;
				if (!have_q) begin
					res_pos_q <= pos_q;
					res_vel_q <= '0;
					res_act_q <= 1'b0;
				end else begin
					res_pos_q <= rd_pos;
					res_vel_q <= rd_vel;
					res_act_q <= 1'b1;
				end
			end
			S_SRCH: begin
				if (rel_q < rd_time) begin
					t1_q <= rd_time;
					p1_q <= rd_pos;
					v1_q <= rd_vel;
				end else begin
					idx_q <= 2'(idx_q + 2'd1);
				end
			end
			S_LD0: begin
				t0_q <= rd_time;
				p0_q <= rd_pos;
				v0_q <= rd_vel;
			end
			S_PSET: begin
				e_q     <= rel_q - t0_q;
				dt_q    <= t1_q - t0_q;
				pneg_q  <= dp[28];
				div_a_q <= dp[28] ? 29'(-dp) : 29'(dp);
				div_b_q <= rel_q - t0_q;
				div_d_q <= t1_q - t0_q;
				vneg_q  <= dv[20];
				vmag_q  <= dv[20] ? 21'(-dv) : 21'(dv);
			end
			S_PDIV: begin
				if (div_res.done) begin
					res_pos_q <= pneg_q ? p0_q - $signed(div_res.quot[27:0])
					                    : p0_q + $signed(div_res.quot[27:0]);
					div_a_q   <= {8'b0, vmag_q};
					div_b_q   <= e_q;
					div_d_q   <= dt_q;
				end
			end
			S_VDIV: begin
				if (div_res.done) begin
					res_vel_q <= vneg_q ? v0_q - $signed(div_res.quot[19:0])
					                    : v0_q + $signed(div_res.quot[19:0]);
					res_act_q <= 1'b1;
				end
			end
			S_OUT: begin
				if (!sp_valid_q || !sp_stall) begin
					sp_q.setpoint_position <= res_pos_q;
					sp_q.setpoint_velocity <= res_vel_q;
					sp_q.profile_active    <= res_act_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign sp_valid  = sp_valid_q;
	assign sp_item   = sp_q;
	assign cfg_ready = 1'b1;

	// The sequencer holds exactly one state at all times.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state is not one-hot");

	// An accepted item always moves the sequencer to the command check.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == S_CMP))
		else $error("accepted item did not start the command check");

	// A stored profile always has at least a start and an end knot.
	assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> (kcnt_q == 3'd3 || kcnt_q == 3'd4))
		else $error("stored profile has a bad knot count");

	// The shared divider only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_D1 || state_q == S_D2 ||
		                  state_q == S_PDIV || state_q == S_VDIV))
		else $error("divider finished outside a wait state");

	// A result enters the output register only when that register is free or being drained.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && sp_valid_q && sp_stall) |=> (state_q == S_OUT))
		else $error("result left the sequencer while the output was held");

endmodule
